FILE: hdl/klpa_pkg.sv
`timescale 1ns / 1ps

package klpa_pkg;

   // Slot table size and the widths that follow from it.
   localparam int SLOTS  = 4;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int KEY_W  = 8;
   localparam int TIME_W = 32;
   localparam int CFG_W  = 16;

   // Request queue between the front and the back. The pointers wrap
   // naturally, so the depth must be a power of two.
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Port packing.
   localparam int REQ_DATA_W = KEY_W + TIME_W;
   localparam int RSP_DATA_W = KEY_W;

   // Register indexes on the CSR port.
   localparam logic CSR_LONG_PRESS = 1'b0;
   localparam logic CSR_REPEAT     = 1'b1;

   localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd600;
   localparam logic [CFG_W-1:0] REPEAT_RESET     = 16'd150;

   typedef enum logic [1:0] {
      ACT_PRESS       = 2'd0,
      ACT_RELEASE     = 2'd1,
      ACT_TICK        = 2'd2,
      ACT_RELEASE_ALL = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      EV_DOWN   = 2'd0,
      EV_UP     = 2'd1,
      EV_LONG   = 2'd2,
      EV_REPEAT = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_TICK  = 2'd1,
      ST_FLUSH = 2'd2
   } eng_state_type;

   // One classified request as it waits in the queue.
   typedef struct packed {
      action_type        action;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now;
   } cmd_type;

endpackage

FILE: hdl/klpa_front.sv
`timescale 1ns / 1ps

module klpa_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_tuser,  // action
   input  logic [klpa_pkg::REQ_DATA_W-1:0]     req_tdata,  // key_code, now_ms
   output logic                                cmd_valid,
   output klpa_pkg::cmd_type                   cmd,
   input  logic                                cmd_pop
);

   klpa_pkg::cmd_type                 q_mem [klpa_pkg::QDEPTH];
   logic [klpa_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [klpa_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [klpa_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              push;
   klpa_pkg::cmd_type                 req_cmd;

   // Classify the incoming request into a command.
   always_comb begin
      req_cmd.action = klpa_pkg::action_type'(req_tuser);
      req_cmd.key    = req_tdata[klpa_pkg::KEY_W-1:0];
      req_cmd.now    = req_tdata[klpa_pkg::KEY_W +: klpa_pkg::TIME_W];
   end

   assign req_tready = (count_ff != klpa_pkg::QCNT_W'(klpa_pkg::QDEPTH));
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != '0);
   assign cmd        = q_mem[rd_ptr_ff];

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + klpa_pkg::QCNT_W'(push) - klpa_pkg::QCNT_W'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= req_cmd;
      end
   end

endmodule

FILE: hdl/klpa_back.sv
`timescale 1ns / 1ps

module klpa_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [klpa_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                                cmd_valid,
   input  klpa_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [1:0]                          rsp_tuser,  // event_kind
   output logic [klpa_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // event_key
   output logic                                rsp_tlast
);

   localparam int SLOTS  = klpa_pkg::SLOTS;
   localparam int SLOT_W = klpa_pkg::SLOT_W;
   localparam int KEY_W  = klpa_pkg::KEY_W;
   localparam int TIME_W = klpa_pkg::TIME_W;
   localparam int CFG_W  = klpa_pkg::CFG_W;

   // Configuration.
   logic [CFG_W-1:0]  long_press_ff, long_press_in;
   logic [CFG_W-1:0]  repeat_ff, repeat_in;

   // Engine control.
   klpa_pkg::eng_state_type state_ff, state_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [TIME_W-1:0] now_ff, now_in;

   // Slot table.
   logic [SLOTS-1:0]  live_ff, live_in;
   logic [SLOTS-1:0]  long_done_ff, long_done_in;
   logic [KEY_W-1:0]  key_ff [SLOTS];
   logic [KEY_W-1:0]  key_in [SLOTS];
   logic [TIME_W-1:0] press_ff [SLOTS];
   logic [TIME_W-1:0] press_in [SLOTS];
   logic [TIME_W-1:0] last_ff [SLOTS];
   logic [TIME_W-1:0] last_in [SLOTS];

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              emit;
   klpa_pkg::event_type ev_kind;
   logic [KEY_W-1:0]  ev_key;
   logic              ev_last;

   // Lookup results over the whole table.
   logic              held;
   logic              has_free;
   logic [SLOT_W-1:0] free_idx;
   logic              rel_hit;
   logic [SLOT_W-1:0] rel_idx;
   logic [SLOTS-1:0]  above_mask;
   logic              live_above;

   // Current scan slot.
   logic              cur_live;
   logic              cur_long_done;
   logic [TIME_W-1:0] elapsed;
   logic [CFG_W-1:0]  threshold;
   logic              due;
   logic              last_idx;
   logic              tick_done;
   logic              flush_done;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Key match and lowest free slot.
   always_comb begin
      held     = 1'b0;
      has_free = 1'b0;
      free_idx = '0;
      rel_hit  = 1'b0;
      rel_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (live_ff[i] && (key_ff[i] == cmd.key)) begin
            held    = 1'b1;
            rel_hit = 1'b1;
            rel_idx = SLOT_W'(i);
         end
         if (!live_ff[i]) begin
            has_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // Live slots past the scan position decide the last key-up of a flush.
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         above_mask[i] = (SLOT_W'(i) > idx_ff);
      end
      live_above = |(live_ff & above_mask);
   end

   // Elapsed time of the slot under scan against its threshold.
   always_comb begin
      cur_live      = live_ff[idx_ff];
      cur_long_done = long_done_ff[idx_ff];
      elapsed       = now_ff - (cur_long_done ? last_ff[idx_ff] : press_ff[idx_ff]);
      threshold     = cur_long_done ? repeat_ff : long_press_ff;
      due           = (elapsed >= {{(TIME_W - CFG_W){1'b0}}, threshold});
      last_idx      = (idx_ff == SLOT_W'(SLOTS - 1));
      tick_done     = (cur_live && due) ? out_free : last_idx;
      flush_done    = (!cur_live || out_free) && (last_idx || !live_above);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         klpa_pkg::ST_IDLE: begin
            if (cmd_valid && (cmd.action == klpa_pkg::ACT_TICK)) begin
               state_in = klpa_pkg::ST_TICK;
            end else if (cmd_valid && (cmd.action == klpa_pkg::ACT_RELEASE_ALL)) begin
               state_in = klpa_pkg::ST_FLUSH;
            end
         end
         klpa_pkg::ST_TICK: begin
            if (tick_done) begin
               state_in = klpa_pkg::ST_IDLE;
            end
         end
         klpa_pkg::ST_FLUSH: begin
            if (flush_done) begin
               state_in = klpa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = klpa_pkg::ST_IDLE;
         end
      endcase
   end

   // Engine outputs and slot table updates.
   always_comb begin
      cmd_pop      = 1'b0;
      emit         = 1'b0;
      ev_kind      = klpa_pkg::EV_DOWN;
      ev_key       = cmd.key;
      ev_last      = 1'b1;
      idx_in       = idx_ff;
      now_in       = now_ff;
      live_in      = live_ff;
      long_done_in = long_done_ff;
      key_in       = key_ff;
      press_in     = press_ff;
      last_in      = last_ff;

      unique case (state_ff)
         klpa_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.action)
                  klpa_pkg::ACT_PRESS: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        if (!held && has_free) begin
                           key_in[free_idx]       = cmd.key;
                           press_in[free_idx]     = cmd.now;
                           last_in[free_idx]      = cmd.now;
                           live_in[free_idx]      = 1'b1;
                           long_done_in[free_idx] = 1'b0;
                           emit                   = 1'b1;
                           ev_kind                = klpa_pkg::EV_DOWN;
                        end
                     end
                  end
                  klpa_pkg::ACT_RELEASE: begin
                     if (out_free) begin
                        cmd_pop = 1'b1;
                        emit    = 1'b1;
                        ev_kind = klpa_pkg::EV_UP;
                        if (rel_hit) begin
                           live_in[rel_idx] = 1'b0;
                        end
                     end
                  end
                  klpa_pkg::ACT_TICK, klpa_pkg::ACT_RELEASE_ALL: begin
                     cmd_pop = 1'b1;
                     idx_in  = '0;
                     now_in  = cmd.now;
                  end
               endcase
            end
         end
         klpa_pkg::ST_TICK: begin
            if (cur_live && due) begin
               if (out_free) begin
                  emit                 = 1'b1;
                  ev_kind              = cur_long_done ? klpa_pkg::EV_REPEAT
                                                       : klpa_pkg::EV_LONG;
                  ev_key               = key_ff[idx_ff];
                  long_done_in[idx_ff] = 1'b1;
                  last_in[idx_ff]      = now_ff;
               end
            end else if (!last_idx) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         klpa_pkg::ST_FLUSH: begin
            if (cur_live) begin
               if (out_free) begin
                  emit            = 1'b1;
                  ev_kind         = klpa_pkg::EV_UP;
                  ev_key          = key_ff[idx_ff];
                  ev_last         = !live_above;
                  live_in[idx_ff] = 1'b0;
                  if (!last_idx) begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end else if (!last_idx) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            idx_in = '0;
         end
      endcase
   end

   // Configuration writes.
   always_comb begin
      long_press_in = long_press_ff;
      repeat_in     = repeat_ff;
      if (csr_we) begin
         unique case (csr_index)
            klpa_pkg::CSR_LONG_PRESS: long_press_in = csr_wdata;
            klpa_pkg::CSR_REPEAT:     repeat_in     = csr_wdata;
         endcase
      end
   end

   // Output register: loads when the engine emits, clears when taken.
   always_comb begin
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_kind_in  = emit ? ev_kind : rsp_kind_ff;
      rsp_key_in   = emit ? ev_key : rsp_key_ff;
      rsp_last_in  = emit ? ev_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= klpa_pkg::ST_IDLE;
         idx_ff        <= '0;
         live_ff       <= '0;
         long_done_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         long_press_ff <= klpa_pkg::LONG_PRESS_RESET;
         repeat_ff     <= klpa_pkg::REPEAT_RESET;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         live_ff       <= live_in;
         long_done_ff  <= long_done_in;
         rsp_valid_ff  <= rsp_valid_in;
         long_press_ff <= long_press_in;
         repeat_ff     <= repeat_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      now_ff      <= now_in;
      key_ff      <= key_in;
      press_ff    <= press_in;
      last_ff     <= last_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_key_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/key_long_press_autorepeat.sv
// A press or release result passes through the request queue and then the output
// register. Press and release requests are taken one at a time; a tick or a
// release-all takes the request and then scans the slots one at a time, and the
// scan stops early once nothing is left to do. Output stalls hold the engine.
// A two-entry request queue keeps accepting until full while the scan or output stalls.
// Reset is synchronous and active high; it clears all slots and restores the
// long-press and repeat registers to 600 and 150.
`timescale 1ns / 1ps

module key_long_press_autorepeat (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [klpa_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [1:0]                          req_tuser,  // action
   input  logic [klpa_pkg::REQ_DATA_W-1:0]     req_tdata,  // key_code, now_ms
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [1:0]                          rsp_tuser,  // event_kind
   output logic [klpa_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // event_key
   output logic                                rsp_tlast
);

   logic              cmd_valid;
   logic              cmd_pop;
   klpa_pkg::cmd_type cmd;

   // Front: accepts and queues requests.
   klpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   // Back: slot table, scan engine and result register.
   klpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: hdl/klpa_checker.sv
`timescale 1ns / 1ps

module klpa_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [1:0]                          rsp_tuser,
   input logic [klpa_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic                                rsp_tlast
);

   // No result is pending right after reset.
   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The request queue is empty after reset, so a request can be taken.
   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_tready)
      else $error("request not ready after reset");

   // Only a release-all gives several results; every other event closes its request.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != klpa_pkg::EV_UP)) |-> rsp_tlast)
      else $error("non key-up event without last");

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind key_long_press_autorepeat klpa_checker u_klpa_checker (.*);

FILE: dv/key_event_checker.sv
`timescale 1ns / 1ps

module key_event_checker
   import klpa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [1:0]            req_tuser,  // action
   input  logic [REQ_DATA_W-1:0] req_tdata,  // key_code, now_ms
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [1:0]            rsp_tuser,  // event_kind
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // event_key
   input  logic                  rsp_tlast,
   output int                    error_count,
   output int                    events_due
);

   typedef struct packed {
      event_type        kind;
      logic [KEY_W-1:0] key;
      logic             last;
   } key_event_type;

   // Events predicted for accepted requests, oldest first.
   key_event_type event_queue[$];

   // Shadow copy of the hold table and the timing registers.
   logic [CFG_W-1:0]  hold_limit;
   logic [CFG_W-1:0]  repeat_gap;
   logic              slot_busy   [SLOTS];
   logic              slot_long   [SLOTS];
   logic [KEY_W-1:0]  slot_code   [SLOTS];
   logic [TIME_W-1:0] slot_t_press[SLOTS];
   logic [TIME_W-1:0] slot_t_last [SLOTS];

   int errors = 0;

   task automatic log_mismatch(input string msg);
      errors++;
      if (errors <= 10) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
   endtask

   // Updates the hold table for one request and queues the events it causes.
   task automatic predict_events(input action_type act, input logic [KEY_W-1:0] code,
                                 input logic [TIME_W-1:0] stamp);
      int                start_size;
      int                free_idx;
      bit                held;
      bit                done;
      logic [TIME_W-1:0] elapsed;
      start_size = event_queue.size();
      free_idx = -1;
      held = 1'b0;
      done = 1'b0;
      case (act)
         ACT_PRESS: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_busy[i] && slot_code[i] == code) held = 1'b1;
               if (!slot_busy[i] && free_idx < 0) free_idx = i;
            end
            // A held key is ignored and a full table drops the press.
            if (!held && free_idx >= 0) begin
               slot_busy[free_idx]    = 1'b1;
               slot_long[free_idx]    = 1'b0;
               slot_code[free_idx]    = code;
               slot_t_press[free_idx] = stamp;
               slot_t_last[free_idx]  = stamp;
               event_queue.push_back('{EV_DOWN, code, 1'b0});
            end
         end
         ACT_RELEASE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && slot_busy[i] && slot_code[i] == code) begin
                  slot_busy[i] = 1'b0;
                  done = 1'b1;
               end
            end
            // Key-up goes out even when the key was not held.
            event_queue.push_back('{EV_UP, code, 1'b0});
         end
         ACT_TICK: begin
            // The first live slot that is due gets the only event of the tick.
            for (int i = 0; i < SLOTS; i++) begin
               if (!done && slot_busy[i]) begin
                  if (!slot_long[i]) begin
                     elapsed = stamp - slot_t_press[i];
                     if (elapsed >= hold_limit) begin
                        slot_long[i]   = 1'b1;
                        slot_t_last[i] = stamp;
                        event_queue.push_back('{EV_LONG, slot_code[i], 1'b0});
                        done = 1'b1;
                     end
                  end else begin
                     elapsed = stamp - slot_t_last[i];
                     if (elapsed >= repeat_gap) begin
                        slot_t_last[i] = stamp;
                        event_queue.push_back('{EV_REPEAT, slot_code[i], 1'b0});
                        done = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_busy[i]) begin
                  slot_busy[i] = 1'b0;
                  event_queue.push_back('{EV_UP, slot_code[i], 1'b0});
               end
            end
         end
      endcase
      if (event_queue.size() > start_size) begin
         event_queue[event_queue.size()-1].last = 1'b1;
      end
   endtask

   // Results are checked before the request of the same edge is predicted,
   // since a result never belongs to a request accepted at the same edge.
   always @(posedge clock) begin
      key_event_type want;
      if (reset) begin
         hold_limit = LONG_PRESS_RESET;
         repeat_gap = REPEAT_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i] = 1'b0;
            slot_long[i] = 1'b0;
         end
         event_queue.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_LONG_PRESS) hold_limit = csr_wdata;
            else repeat_gap = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (event_queue.size() == 0) begin
               log_mismatch($sformatf("unexpected result kind %0d key 0x%02h last %0d",
                                      rsp_tuser, rsp_tdata, rsp_tlast));
            end else begin
               want = event_queue.pop_front();
               if (rsp_tuser != want.kind || rsp_tdata != want.key ||
                   rsp_tlast != want.last) begin
                  log_mismatch($sformatf(
                     "expected kind %0d key 0x%02h last %0d, got kind %0d key 0x%02h last %0d",
                     want.kind, want.key, want.last, rsp_tuser, rsp_tdata, rsp_tlast));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            predict_events(action_type'(req_tuser), req_tdata[KEY_W-1:0],
                           req_tdata[KEY_W +: TIME_W]);
         end
      end
      error_count <= errors;
      events_due  <= event_queue.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import klpa_pkg::*;

   localparam int RESET_CYCLES     = 7;
   localparam int DRAIN_CYCLES     = 24;
   localparam int STALL_LIMIT      = 2000;
   localparam int RANDOM_PER_PHASE = 69;
   localparam int PHASES           = 5;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = 1'b0;
   logic [CFG_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [1:0]            req_tuser  = '0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   int mismatches;
   int events_due;
   int idle_cycles = 0;

   // Stimulus state: the running millisecond clock, the current timing
   // registers and a small set of keys so that presses and releases meet.
   bit                steady = 1'b0;
   logic [TIME_W-1:0] ms_now;
   logic [CFG_W-1:0]  cur_hold;
   logic [CFG_W-1:0]  cur_gap;
   logic [KEY_W-1:0]  key_pool[6];

   always #5 clock = ~clock;

   key_long_press_autorepeat u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   key_event_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .error_count (mismatches),
      .events_due  (events_due)
   );

   // The result side stalls at random, except during the steady stretch.
   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 11);
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request, sometimes after a short gap, and waits until it is taken.
   task automatic send_request(input action_type act, input logic [KEY_W-1:0] code,
                               input logic [TIME_W-1:0] stamp);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 11) gap = $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {stamp, code};
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits until every predicted event has arrived and the scan has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (events_due != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_timing(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] gap_ms);
      csr_we    <= 1'b1;
      csr_index <= CSR_LONG_PRESS;
      csr_wdata <= hold;
      @(posedge clock);
      csr_index <= CSR_REPEAT;
      csr_wdata <= gap_ms;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cur_hold = hold;
      cur_gap  = gap_ms;
   endtask

   // Mostly well-formed key traffic on a moving clock, with some noise.
   task automatic random_request();
      int               pick;
      int               span;
      logic [KEY_W-1:0] code;
      pick = $urandom_range(99);
      span = ((cur_hold > cur_gap) ? cur_hold : cur_gap) / 3 + 1;
      code = ($urandom_range(9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(5)];
      ms_now = ms_now + $urandom_range(span);
      if (pick < 30) begin
         send_request(ACT_PRESS, code, ms_now);
      end else if (pick < 48) begin
         send_request(ACT_RELEASE, code, TIME_W'($urandom));
      end else if (pick < 90) begin
         send_request(ACT_TICK, KEY_W'($urandom), ms_now);
      end else if (pick < 95) begin
         send_request(ACT_RELEASE_ALL, KEY_W'($urandom), TIME_W'($urandom));
      end else begin
         send_request(action_type'($urandom_range(3)), KEY_W'($urandom), TIME_W'($urandom));
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      cur_hold = LONG_PRESS_RESET;
      cur_gap  = REPEAT_RESET;

      // Reset timing: empty table, duplicate press, full table and time wrap.
      send_request(ACT_TICK, 8'h00, 32'h0000_0000);
      send_request(ACT_RELEASE_ALL, 8'hFF, 32'hFFFF_FFFF);
      send_request(ACT_RELEASE, 8'h00, 32'h0000_0000);
      send_request(ACT_PRESS, 8'h00, 32'hFFFF_FF00);
      send_request(ACT_PRESS, 8'h00, 32'hFFFF_FF10);
      send_request(ACT_PRESS, 8'hFF, 32'hFFFF_FF80);
      send_request(ACT_PRESS, 8'h5A, 32'hFFFF_FFC0);
      send_request(ACT_PRESS, 8'hA5, 32'hFFFF_FFFF);
      send_request(ACT_PRESS, 8'h11, 32'h0000_0000);
      send_request(ACT_TICK, 8'h00, 32'hFFFF_FFFF);
      // Long press of the first key across the wrap, then nothing due.
      send_request(ACT_TICK, 8'h00, 32'h0000_0160);
      send_request(ACT_TICK, 8'h00, 32'h0000_0160);
      // Repeat of the first key exactly one interval later.
      send_request(ACT_TICK, 8'h00, 32'h0000_01F6);
      send_request(ACT_TICK, 8'h00, 32'h0000_0260);
      send_request(ACT_RELEASE, 8'hFF, 32'h0000_0000);
      send_request(ACT_PRESS, 8'h33, 32'h0000_0300);
      send_request(ACT_RELEASE_ALL, 8'h00, 32'h0000_0000);
      send_request(ACT_TICK, 8'h00, 32'h0000_0400);
      drain();

      // Zero timing: long press and repeat fire on every tick.
      set_timing(16'd0, 16'd0);
      send_request(ACT_PRESS, 8'h42, 32'h1234_5678);
      send_request(ACT_TICK, 8'h00, 32'h1234_5678);
      send_request(ACT_TICK, 8'h00, 32'h1234_5678);
      send_request(ACT_TICK, 8'h00, 32'h1234_5677);
      send_request(ACT_RELEASE_ALL, 8'h00, 32'h0000_0000);
      drain();

      // Random traffic under several timing settings.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: set_timing(16'd1, 16'd1);
            1: set_timing(16'hFFFF, 16'hFFFF);
            2: set_timing(CFG_W'($urandom), CFG_W'($urandom));
            3: set_timing(CFG_W'($urandom_range(20, 800)), CFG_W'($urandom_range(10, 300)));
            default: set_timing(16'd0, 16'd0);
         endcase
         ms_now = (ph == 1) ? 32'hFFFE_0000 : TIME_W'($urandom);
         foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            steady = (ph == 3) && (n < RANDOM_PER_PHASE / 2);
            random_request();
         end
         steady = 1'b0;
         drain();
      end

      if (mismatches == 0 && events_due == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
